@@ rtl/arp_pkg.sv @@
// package: shared constants, codes and result type of the arp resolver cache
package arp_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF   = 16;
  localparam int unsigned PENDING_ENTRIES_DEF = 16;
  localparam int unsigned TAG_BITS_DEF        = 8;
  localparam int unsigned MAX_RESULTS         = 16;

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] OP_RX_REQ = 2'd0;
  localparam logic [1:0] OP_RX_REP = 2'd1;
  localparam logic [1:0] OP_SEND   = 2'd2;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_REPLY   = 3'd1;
  localparam logic [2:0] ACT_REQUEST = 3'd2;
  localparam logic [2:0] ACT_SEND    = 3'd3;
  localparam logic [2:0] ACT_INVALID = 3'd4;
  localparam logic [2:0] ACT_FULL    = 3'd5;

  localparam logic [1:0] REG_OWN_IP   = 2'd0;
  localparam logic [1:0] REG_OWN_MAC  = 2'd1;
  localparam logic [1:0] REG_SUB_MASK = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] dest_mac;
    logic [31:0] dest_ip;
    logic [7:0]  out_tag;
    logic [15:0] out_type;
  } res_t;

endpackage

@@ rtl/arp_if.sv @@
// interfaces: request and result channels of the arp resolver cache
interface arp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] ip_addr;
  logic [47:0] mac_addr;
  logic [31:0] target_ip;
  logic [7:0]  packet_tag;
  logic [15:0] pkt_type;
  modport source (output valid, opcode, ip_addr, mac_addr, target_ip, packet_tag, pkt_type,
                  input ready);
  modport sink (input valid, opcode, ip_addr, mac_addr, target_ip, packet_tag, pkt_type,
                output ready);
endinterface

interface arp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [47:0] dest_mac;
  logic [31:0] dest_ip;
  logic [7:0]  out_tag;
  logic [15:0] out_type;
  logic        last;
  modport source (output valid, action, dest_mac, dest_ip, out_tag, out_type, last,
                  input ready);
  modport sink (input valid, action, dest_mac, dest_ip, out_tag, out_type, last,
                output ready);
endinterface

@@ rtl/arp_resolver_cache.sv @@
// top level: arp cache, responder and pending packet queue
// One request is taken at a time. The cache sits in a memory and every lookup scans it one
// entry per cycle. A received reply walks the pending queue and looks up each queued entry
// until MAX_RESULTS results have been sent; entries that miss or are not looked up stay queued.
// Results go through an output register, so a waiting result does not stop the walk
// until a second one is ready. There is no clearing pass after reset.
module arp_resolver_cache #(
  parameter int unsigned CACHE_ENTRIES   = arp_pkg::CACHE_ENTRIES_DEF,
  parameter int unsigned PENDING_ENTRIES = arp_pkg::PENDING_ENTRIES_DEF,
  parameter int unsigned TAG_BITS        = arp_pkg::TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  arp_in_if.sink      in_req,
  arp_out_if.source   out_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [47:0] cfg_data
);

  localparam int unsigned IW = $clog2(CACHE_ENTRIES);
  localparam int unsigned SW = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(PENDING_ENTRIES + 1);
  localparam int unsigned NW = $clog2(arp_pkg::MAX_RESULTS + 1);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCAN  = 8'b0000_0010,
    ST_STORE = 8'b0000_0100,
    ST_SDEC  = 8'b0000_1000,
    ST_RSEL  = 8'b0001_0000,
    ST_RWAIT = 8'b0010_0000,
    ST_RDEC  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r;

  logic [31:0] own_ip_r, mask_r;
  logic [47:0] own_mac_r;

  logic [1:0]          op_r;
  logic [31:0]         ip_r, tip_r;
  logic [47:0]         mac_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [15:0]         type_r;

  logic [31:0] cache_ip_mem  [CACHE_ENTRIES];
  logic [47:0] cache_mac_mem [CACHE_ENTRIES];
  logic [31:0] cache_ip_q;
  logic [47:0] cache_mac_q;
  logic [CACHE_ENTRIES-1:0] vld_r;
  logic [IW-1:0] rp_r;

  logic [31:0]         pend_ip_mem   [PENDING_ENTRIES];
  logic [TAG_BITS-1:0] pend_tag_mem  [PENDING_ENTRIES];
  logic [15:0]         pend_type_mem [PENDING_ENTRIES];
  logic [31:0]         pend_ip_q;
  logic [TAG_BITS-1:0] pend_tag_q;
  logic [15:0]         pend_type_q;
  logic [CW-1:0]       cnt_r, ri_r, w_r;

  logic [31:0]   scan_ip_r;
  logic [SW-1:0] iss_r;
  logic          cmp_v_r;
  logic [IW-1:0] cmp_idx_r;
  logic          rel_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic [47:0]   hit_mac_r;

  arp_pkg::res_t   hold_r;
  logic            hold_v_r;
  logic [NW-1:0]   n_r;

  logic            out_v_r, out_last_r;
  arp_pkg::res_t   out_q_r;

  logic            out_free, push_en, push_last;
  arp_pkg::res_t   push_res;
  logic            scan_hit, scan_end, scan_issue;
  logic            c_we;
  logic [IW-1:0]   c_waddr;
  logic            p_we, p_re;
  logic [PW-1:0]   p_waddr, p_raddr;
  logic [31:0]     p_wip;
  logic [TAG_BITS-1:0] p_wtag;
  logic [15:0]     p_wtype;

  logic [31:0]   in_host;
  logic          in_is_host, in_is_bcast, accept;
  logic [15:0]   in_tag16;
  logic [TAG_BITS-1:0] in_tag;

  function automatic logic [7:0] tag_out(input logic [TAG_BITS-1:0] t);
    logic [15:0] w;
    w = 16'(t);
    return w[7:0];
  endfunction

  assign accept      = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);
  assign in_host     = in_req.ip_addr & ~mask_r;
  assign in_is_host  = (in_host != 32'd0) && (in_host != ~mask_r);
  assign in_is_bcast = (in_req.ip_addr == ((in_req.ip_addr & mask_r) | ~mask_r));
  assign in_tag16    = {8'd0, in_req.packet_tag};
  assign in_tag      = in_tag16[TAG_BITS-1:0];

  assign out_free = !out_v_r || out_res.ready;
  assign scan_hit = cmp_v_r && vld_r[cmp_idx_r] && (cache_ip_q == scan_ip_r);
  assign scan_end = cmp_v_r && (cmp_idx_r == IW'(CACHE_ENTRIES - 1));
  assign scan_issue = (state_r == ST_SCAN) && !scan_hit && !scan_end &&
                      (iss_r < SW'(CACHE_ENTRIES));

  // memory and output control
  always_comb begin
    c_we     = (state_r == ST_STORE);
    c_waddr  = hit_r ? hit_idx_r : rp_r;
    p_re     = (state_r == ST_RSEL) && (ri_r != cnt_r);
    p_raddr  = ri_r[PW-1:0];
    p_we     = 1'b0;
    p_waddr  = w_r[PW-1:0];
    p_wip    = pend_ip_q;
    p_wtag   = pend_tag_q;
    p_wtype  = pend_type_q;
    push_en  = 1'b0;
    push_last = 1'b0;
    push_res = hold_r;
    unique case (state_r)
      ST_SDEC: begin
        if (!hit_r && (cnt_r != CW'(PENDING_ENTRIES))) begin
          p_we    = 1'b1;
          p_waddr = cnt_r[PW-1:0];
          p_wip   = ip_r;
          p_wtag  = tag_r;
          p_wtype = type_r;
        end
      end
      ST_RWAIT: p_we = (n_r == NW'(arp_pkg::MAX_RESULTS));
      ST_RDEC: begin
        p_we    = !hit_r;
        push_en = hit_r && hold_v_r && out_free;
      end
      ST_FIN: begin
        push_en   = out_free;
        push_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cache_ip_q  <= cache_ip_mem[iss_r[IW-1:0]];
    cache_mac_q <= cache_mac_mem[iss_r[IW-1:0]];
    if (c_we) begin
      cache_ip_mem[c_waddr]  <= ip_r;
      cache_mac_mem[c_waddr] <= mac_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_re) begin
      pend_ip_q   <= pend_ip_mem[p_raddr];
      pend_tag_q  <= pend_tag_mem[p_raddr];
      pend_type_q <= pend_type_mem[p_raddr];
    end
    if (p_we) begin
      pend_ip_mem[p_waddr]   <= p_wip;
      pend_tag_mem[p_waddr]  <= p_wtag;
      pend_type_mem[p_waddr] <= p_wtype;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push_en) begin
      out_v_r <= 1'b1;
    end else if (out_res.ready) begin
      out_v_r <= 1'b0;
    end
    if (push_en) begin
      out_q_r    <= push_res;
      out_last_r <= push_last;
    end
  end

  assign out_res.valid    = out_v_r;
  assign out_res.action   = out_q_r.action;
  assign out_res.dest_mac = out_q_r.dest_mac;
  assign out_res.dest_ip  = out_q_r.dest_ip;
  assign out_res.out_tag  = out_q_r.out_tag;
  assign out_res.out_type = out_q_r.out_type;
  assign out_res.last     = out_last_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      own_mac_r <= '0;
      mask_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        arp_pkg::REG_OWN_IP:   own_ip_r  <= cfg_data[31:0];
        arp_pkg::REG_OWN_MAC:  own_mac_r <= cfg_data;
        arp_pkg::REG_SUB_MASK: mask_r    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vld_r    <= '0;
      rp_r     <= '0;
      cnt_r    <= '0;
      cmp_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
      iss_r    <= '0;
    end else begin
      cmp_v_r   <= scan_issue;
      cmp_idx_r <= iss_r[IW-1:0];
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r      <= in_req.opcode;
            ip_r      <= in_req.ip_addr;
            mac_r     <= in_req.mac_addr;
            tip_r     <= in_req.target_ip;
            tag_r     <= in_tag;
            type_r    <= in_req.pkt_type;
            scan_ip_r <= in_req.ip_addr;
            iss_r     <= '0;
            rel_r     <= 1'b0;
            unique case (in_req.opcode)
              arp_pkg::OP_RX_REQ: begin
                hold_r <= '{arp_pkg::ACT_INVALID, 48'd0, 32'd0, 8'd0, 16'd0};
                if (in_is_host && (in_req.mac_addr != arp_pkg::BCAST_MAC)) state_r <= ST_SCAN;
                else state_r <= ST_FIN;
              end
              arp_pkg::OP_RX_REP: state_r <= ST_SCAN;
              arp_pkg::OP_SEND: begin
                if (in_is_bcast) begin
                  hold_r <= '{arp_pkg::ACT_SEND, arp_pkg::BCAST_MAC, in_req.ip_addr,
                              tag_out(in_tag), in_req.pkt_type};
                  state_r <= ST_FIN;
                end else if (in_req.ip_addr == own_ip_r) begin
                  hold_r <= '{arp_pkg::ACT_SEND, own_mac_r, in_req.ip_addr,
                              tag_out(in_tag), in_req.pkt_type};
                  state_r <= ST_FIN;
                end else begin
                  state_r <= ST_SCAN;
                end
              end
              default: begin
                hold_r  <= '{arp_pkg::ACT_INVALID, 48'd0, 32'd0, 8'd0, 16'd0};
                state_r <= ST_FIN;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_hit || scan_end) begin
            hit_r     <= scan_hit;
            hit_idx_r <= cmp_idx_r;
            hit_mac_r <= cache_mac_q;
            if (rel_r) state_r <= ST_RDEC;
            else if (op_r == arp_pkg::OP_SEND) state_r <= ST_SDEC;
            else state_r <= ST_STORE;
          end else if (iss_r < SW'(CACHE_ENTRIES)) begin
            iss_r   <= iss_r + SW'(1);
          end
        end
        ST_STORE: begin
          vld_r[c_waddr] <= 1'b1;
          if (!hit_r) rp_r <= (rp_r == IW'(CACHE_ENTRIES - 1)) ? '0 : rp_r + IW'(1);
          if (op_r == arp_pkg::OP_RX_REQ) begin
            if (tip_r == own_ip_r)
              hold_r <= '{arp_pkg::ACT_REPLY, mac_r, ip_r, 8'd0, 16'd0};
            else
              hold_r <= '{arp_pkg::ACT_NONE, 48'd0, 32'd0, 8'd0, 16'd0};
            state_r <= ST_FIN;
          end else begin
            ri_r     <= '0;
            w_r      <= '0;
            n_r      <= '0;
            hold_v_r <= 1'b0;
            state_r  <= ST_RSEL;
          end
        end
        ST_SDEC: begin
          if (hit_r) begin
            hold_r <= '{arp_pkg::ACT_SEND, hit_mac_r, ip_r, tag_out(tag_r), type_r};
          end else if (cnt_r == CW'(PENDING_ENTRIES)) begin
            hold_r <= '{arp_pkg::ACT_FULL, 48'd0, ip_r, tag_out(tag_r), type_r};
          end else begin
            cnt_r  <= cnt_r + CW'(1);
            hold_r <= '{arp_pkg::ACT_REQUEST, arp_pkg::BCAST_MAC, ip_r, 8'd0, 16'd0};
          end
          state_r <= ST_FIN;
        end
        ST_RSEL: begin
          if (ri_r == cnt_r) begin
            cnt_r <= w_r;
            if (!hold_v_r) hold_r <= '{arp_pkg::ACT_NONE, 48'd0, 32'd0, 8'd0, 16'd0};
            hold_v_r <= 1'b0;
            state_r  <= ST_FIN;
          end else begin
            state_r <= ST_RWAIT;
          end
        end
        ST_RWAIT: begin
          if (n_r == NW'(arp_pkg::MAX_RESULTS)) begin
            w_r     <= w_r + CW'(1);
            ri_r    <= ri_r + CW'(1);
            state_r <= ST_RSEL;
          end else begin
            scan_ip_r <= pend_ip_q;
            iss_r     <= '0;
            rel_r     <= 1'b1;
            state_r   <= ST_SCAN;
          end
        end
        ST_RDEC: begin
          if (!hit_r) begin
            w_r     <= w_r + CW'(1);
            ri_r    <= ri_r + CW'(1);
            state_r <= ST_RSEL;
          end else if (!hold_v_r || out_free) begin
            hold_r   <= '{arp_pkg::ACT_SEND, hit_mac_r, pend_ip_q, tag_out(pend_tag_q),
                          pend_type_q};
            hold_v_r <= 1'b1;
            n_r      <= n_r + NW'(1);
            ri_r     <= ri_r + CW'(1);
            state_r  <= ST_RSEL;
          end
        end
        ST_FIN: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/arp_resolver_cache_chk.sv @@
// checker: port-level assertions for the arp resolver cache, with its bind
module arp_resolver_cache_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_action,
  input logic [47:0] out_dest_mac,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_action) && $stable(out_dest_mac) && $stable(out_last))
    else $error("stalled result changed");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in progress");

  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_action <= arp_pkg::ACT_FULL))
    else $error("unknown action code");

endmodule

bind arp_resolver_cache arp_resolver_cache_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_action  (out_res.action),
  .out_dest_mac(out_res.dest_mac),
  .out_last    (out_res.last)
);
